FILE: rtl/gpu_page_table_mapper_assert.svh
// ----------------------------------------------------------------------------
// gpu page table mapper assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef GPU_PAGE_TABLE_MAPPER_ASSERT_SVH
`define GPU_PAGE_TABLE_MAPPER_ASSERT_SVH

// generic form with explicit clock and active-low reset
`define GPTM_ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// default clock and reset
`define GPTM_ASSERT(lbl, prop, msg) `GPTM_ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/gptm_pkg.sv
// ----------------------------------------------------------------------------
// gptm_pkg
// types, codes and widths shared by the page table mapper modules
// ----------------------------------------------------------------------------
package gptm_pkg;

  localparam int unsigned ENTRIES_DEF = 512;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned VADDR_W    = 32;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned PHYS_W     = 64;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned START_W    = 9;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned MASK_W     = 12;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned NARROW_W   = 32;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned VPN_SUM_W  = 21;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAP_OPEN = 2'd0,
    KIND_MAP_PAGE = 2'd1,
    KIND_UNMAP    = 2'd2,
    KIND_READ     = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_BAD      = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_SEQ      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_WIDE_FORMAT = 2'd1,
    CFG_MASK_WIDE   = 2'd2,
    CFG_MASK_NARROW = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic search_start;
    logic search_step;
    logic unmap_start;
    logic unmap_step;
    logic clear_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic plan_search;
    logic plan_unmap;
    logic search_end;
    logic unmap_last;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/gptm_ctrl.sv
// ----------------------------------------------------------------------------
// gptm_ctrl
// sequencer for table clear, item execution, free-run search and unmap walk
// ----------------------------------------------------------------------------
module gptm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gptm_pkg::dp_stat_t  stat_i,
  output gptm_pkg::ctrl_cmd_t cmd_o
);
  import gptm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_SEARCH = 5'b01000,
    S_FINAL  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   unmap_q, unmap_d;

  always_comb begin
    state_d = state_q;
    unmap_d = unmap_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.plan_search) begin
          cmd_o.search_start = 1'b1;
          unmap_d            = 1'b0;
          state_d            = S_SEARCH;
        end else if (stat_i.plan_unmap) begin
          cmd_o.unmap_start = 1'b1;
          unmap_d           = 1'b1;
          state_d           = S_SEARCH;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SEARCH: begin
        // shared walk state: free-run scan or unmap zeroing
        if (unmap_q) begin
          cmd_o.unmap_step = 1'b1;
          if (stat_i.unmap_last) begin
            state_d = S_FINAL;
          end
        end else begin
          cmd_o.search_step = 1'b1;
          if (stat_i.search_end) begin
            state_d = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      unmap_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unmap_q <= unmap_d;
    end
  end

endmodule

FILE: rtl/gptm_dp.sv
// ----------------------------------------------------------------------------
// gptm_dp
// entry table, allocation state, config registers and result register
// ----------------------------------------------------------------------------
module gptm_dp #(
  parameter int unsigned ENTRIES = gptm_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gptm_pkg::ctrl_cmd_t                 cmd_i,
  output gptm_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [gptm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gptm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [gptm_pkg::KIND_W-1:0]         kind_i,
  input  logic [gptm_pkg::VADDR_W-1:0]        gpu_vaddr_i,
  input  logic [gptm_pkg::CNT_W-1:0]          page_count_i,
  input  logic [gptm_pkg::PHYS_W-1:0]         phys_addr_i,
  input  logic [gptm_pkg::IDX_W-1:0]          entry_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gptm_pkg::STATUS_W-1:0]       status_o,
  output logic [gptm_pkg::START_W-1:0]        start_index_o,
  output logic [gptm_pkg::VALUE_W-1:0]        entry_value_o,
  output logic                                flush_request_o
);
  import gptm_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // config
  logic              en_q, wide_q;
  logic [MASK_W-1:0] vmw_q, vmn_q;

  // captured item
  kind_e              kind_q;
  logic [VADDR_W-1:0] vaddr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PHYS_W-1:0]  phys_q;
  logic [IDX_W-1:0]   idx_q;

  // allocation state
  logic [CW-1:0]    bump_q, bump_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    wp_q, wp_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  // search walk
  logic [CW-1:0]    scan_q;
  logic [AW-1:0]    chk_q, first_q, found_q, first_n;
  logic             rv_q, hit_q, sdone_q;
  logic [CNT_W-1:0] run_q, run_n;
  logic             zero_ent, hit_now, fail_now;

  // unmap walk and clear sweep
  logic [SUM_W-1:0] uk_q, uk_nx;
  logic [CNT_W-1:0] urem_q;
  logic [AW-1:0]    clr_q;

  // table
  logic [VALUE_W-1:0] mem_q [ENTRIES];
  logic [VALUE_W-1:0] rd_data_q;
  logic               rd_en, we;
  logic [AW-1:0]      raddr, waddr;
  logic [VALUE_W-1:0] wdata, page_ent;

  // result register
  logic                out_valid_q;
  status_e             ost_q;
  logic [START_W-1:0]  ostart_q;
  logic [VALUE_W-1:0]  oval_q;
  logic                oflush_q;

  // commit results
  status_e            res_st;
  logic [CW-1:0]      res_start, open_start;
  logic [VALUE_W-1:0] res_val;
  logic               res_flush, ok_open, mp_we;
  logic [SUM_W-1:0]   open_end, bump_end;
  logic [VPN_SUM_W-1:0] vpn_end;
  logic               idx_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      wide_q <= 1'b0;
      vmw_q  <= MASK_W'(1);
      vmn_q  <= MASK_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:      en_q   <= cfg_data_i[0];
        CFG_WIDE_FORMAT: wide_q <= cfg_data_i[0];
        CFG_MASK_WIDE:   vmw_q  <= cfg_data_i[MASK_W-1:0];
        CFG_MASK_NARROW: vmn_q  <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_e'(kind_i);
      vaddr_q <= gpu_vaddr_i;
      cnt_q   <= page_count_i;
      phys_q  <= phys_addr_i;
      idx_q   <= entry_index_i;
    end
  end

  assign idx_in_range = {1'b0, idx_q} < SUM_W'(ENTRIES);
  assign bump_end     = SUM_W'(bump_q) + SUM_W'(cnt_q);
  assign vpn_end      = VPN_SUM_W'(vaddr_q[VADDR_W-1:PAGE_SHIFT]) + VPN_SUM_W'(cnt_q);

  // first-fit evaluation of the entry read last cycle
  assign zero_ent = (rd_data_q == '0);
  assign run_n    = zero_ent ? run_q + CNT_W'(1) : '0;
  assign first_n  = (zero_ent && run_q == '0) ? chk_q : first_q;
  assign hit_now  = rv_q && zero_ent && (run_n == cnt_q);
  assign fail_now = rv_q && !hit_now && (chk_q == AW'(ENTRIES - 1));

  assign uk_nx = uk_q + SUM_W'(1);

  always_comb begin
    stat_o             = '0;
    stat_o.plan_search = en_q && (kind_q == KIND_MAP_OPEN) && !pend_q && (cnt_q != '0)
                         && (vaddr_q == '0) && (bump_end > SUM_W'(ENTRIES));
    stat_o.plan_unmap  = en_q && (kind_q == KIND_UNMAP) && (cnt_q != '0) && idx_in_range;
    stat_o.search_end  = hit_now || fail_now;
    stat_o.unmap_last  = (urem_q == CNT_W'(1)) || (uk_nx >= SUM_W'(ENTRIES));
    stat_o.clear_last  = (clr_q == AW'(ENTRIES - 1));
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign page_ent = wide_q ? {phys_q[PHYS_W-1:PAGE_SHIFT], vmw_q}
                           : {{(VALUE_W-NARROW_W){1'b0}},
                              phys_q[NARROW_W-1:PAGE_SHIFT], vmn_q};

  always_comb begin
    res_st     = ST_OK;
    res_start  = '0;
    res_val    = '0;
    res_flush  = 1'b0;
    ok_open    = 1'b0;
    open_start = '0;
    mp_we      = 1'b0;
    pend_d     = pend_q;
    wp_d       = wp_q;
    rem_d      = rem_q;
    bump_d     = bump_q;
    if (!en_q) begin
      pend_d = 1'b0;
      res_st = ST_INACTIVE;
    end else begin
      case (kind_q)
        KIND_MAP_OPEN: begin
          if (pend_q) begin
            res_st = ST_SEQ;
          end else if (cnt_q == '0) begin
            res_st = ST_BAD;
          end else if (vaddr_q != '0) begin
            if (vaddr_q[PAGE_SHIFT-1:0] != '0) begin
              res_st = ST_BAD;
            end else if (vpn_end > VPN_SUM_W'(ENTRIES)) begin
              res_st = ST_BAD;
            end else begin
              ok_open    = 1'b1;
              open_start = vaddr_q[PAGE_SHIFT +: CW];
            end
          end else if (sdone_q) begin
            if (hit_q) begin
              ok_open    = 1'b1;
              open_start = CW'(found_q);
            end else begin
              res_st = ST_NOSPACE;
            end
          end else begin
            ok_open    = 1'b1;
            open_start = bump_q;
          end
        end
        KIND_MAP_PAGE: begin
          if (!pend_q || rem_q == '0 || wp_q >= CW'(ENTRIES)) begin
            pend_d = 1'b0;
            res_st = ST_SEQ;
          end else begin
            mp_we = 1'b1;
            wp_d  = wp_q + CW'(1);
            rem_d = rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              pend_d    = 1'b0;
              res_flush = 1'b1;
            end
          end
        end
        KIND_UNMAP: begin
          res_flush = 1'b1;
        end
        KIND_READ: begin
          if (idx_in_range) begin
            res_val = rd_data_q;
          end else begin
            res_st = ST_BAD;
          end
        end
        default: ;
      endcase
    end
    open_end = SUM_W'(open_start) + SUM_W'(cnt_q);
    if (ok_open) begin
      pend_d    = 1'b1;
      wp_d      = open_start;
      rem_d     = cnt_q;
      res_start = open_start;
      if (open_end > SUM_W'(bump_q)) begin
        bump_d = open_end[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= '0;
      pend_q <= 1'b0;
      wp_q   <= '0;
      rem_q  <= '0;
    end else if (cmd_i.commit) begin
      bump_q <= bump_d;
      pend_q <= pend_d;
      wp_q   <= wp_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      chk_q   <= '0;
      rv_q    <= 1'b0;
      run_q   <= '0;
      first_q <= '0;
      hit_q   <= 1'b0;
      found_q <= '0;
      sdone_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        sdone_q <= 1'b0;
      end
      if (cmd_i.search_start) begin
        scan_q  <= '0;
        rv_q    <= 1'b0;
        run_q   <= '0;
        first_q <= '0;
      end else if (cmd_i.search_step) begin
        scan_q <= scan_q + CW'(1);
        chk_q  <= scan_q[AW-1:0];
        rv_q   <= (scan_q < CW'(ENTRIES));
        if (rv_q) begin
          run_q   <= run_n;
          first_q <= first_n;
        end
        if (hit_now || fail_now) begin
          sdone_q <= 1'b1;
          hit_q   <= hit_now;
          found_q <= first_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uk_q   <= '0;
      urem_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.unmap_start) begin
        uk_q   <= SUM_W'(idx_q);
        urem_q <= cnt_q;
      end else if (cmd_i.unmap_step) begin
        uk_q   <= uk_nx;
        urem_q <= urem_q - CNT_W'(1);
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // table ports
  always_comb begin
    rd_en = cmd_i.accept || (cmd_i.search_step && scan_q < CW'(ENTRIES));
    raddr = cmd_i.accept ? entry_index_i[AW-1:0] : scan_q[AW-1:0];
    we    = 1'b0;
    waddr = wp_q[AW-1:0];
    wdata = page_ent;
    if (cmd_i.clear_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.unmap_step) begin
      we    = 1'b1;
      waddr = uk_q[AW-1:0];
      wdata = '0;
    end else if (cmd_i.commit && mp_we) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ost_q    <= res_st;
      ostart_q <= START_W'(res_start);
      oval_q   <= res_val;
      oflush_q <= res_flush;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = ost_q;
  assign start_index_o   = ostart_q;
  assign entry_value_o   = oval_q;
  assign flush_request_o = oflush_q;

endmodule

FILE: rtl/gpu_page_table_mapper.sv
// ----------------------------------------------------------------------------
// gpu_page_table_mapper
// flat page table with bump and first-fit run placement, map, unmap and read
// ----------------------------------------------------------------------------
// map page, read, inactive and fixed or bump map open: one table access, then the result
//   register; no new item is taken until the result is committed
// unmap: one entry zeroed per cycle on the write port
// first-fit map open: scans up to all ENTRIES entries, one entry per cycle on the read port
// reset: clearing pass over all ENTRIES entries, no items taken, config writes accepted
module gpu_page_table_mapper #(
  parameter int unsigned ENTRIES = gptm_pkg::ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gptm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gptm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gptm_pkg::KIND_W-1:0]     kind_i,
  input  logic [gptm_pkg::VADDR_W-1:0]    gpu_vaddr_i,
  input  logic [gptm_pkg::CNT_W-1:0]      page_count_i,
  input  logic [gptm_pkg::PHYS_W-1:0]     phys_addr_i,
  input  logic [gptm_pkg::IDX_W-1:0]      entry_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gptm_pkg::STATUS_W-1:0]   status_o,
  output logic [gptm_pkg::START_W-1:0]    start_index_o,
  output logic [gptm_pkg::VALUE_W-1:0]    entry_value_o,
  output logic                            flush_request_o
);
  import gptm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gptm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gptm_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_i),
    .gpu_vaddr_i     (gpu_vaddr_i),
    .page_count_i    (page_count_i),
    .phys_addr_i     (phys_addr_i),
    .entry_index_i   (entry_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .start_index_o   (start_index_o),
    .entry_value_o   (entry_value_o),
    .flush_request_o (flush_request_o)
  );

endmodule

FILE: rtl/gptm_checker.sv
// ----------------------------------------------------------------------------
// gptm_checker
// port-level checks on the page table mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "gpu_page_table_mapper_assert.svh"

module gptm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [gptm_pkg::STATUS_W-1:0]   status_o,
  input logic [gptm_pkg::START_W-1:0]    start_index_o,
  input logic [gptm_pkg::VALUE_W-1:0]    entry_value_o,
  input logic                            flush_request_o
);
  import gptm_pkg::*;

  // one item in work at a time
  `GPTM_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")

  // stalled result holds
  `GPTM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(entry_value_o), "result dropped")

  // flush only on a clean map finish or unmap
  `GPTM_ASSERT(a_flush_ok, out_valid_o && flush_request_o |-> status_o == ST_OK && entry_value_o == '0, "flush on bad item")

  // start index only from a map open
  `GPTM_ASSERT(a_start_open, out_valid_o && start_index_o != '0 |-> status_o == ST_OK && !flush_request_o && entry_value_o == '0, "start index on wrong item")

  // entry data only from a good read
  `GPTM_ASSERT(a_value_read, out_valid_o && entry_value_o != '0 |-> status_o == ST_OK && start_index_o == '0, "entry value on wrong item")

endmodule

bind gpu_page_table_mapper gptm_checker u_gptm_checker (.*);
